### rtl/rsd_pkg.sv
// Shared types and constants of the rotating server dispatcher.
package rsd_pkg;

  localparam int SRV_ID_W = 6;
  localparam int TIME_W   = 31;
  localparam int END_W    = 32;
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic MODE_DISPATCH = 1'b0;
  localparam logic MODE_REPORT   = 1'b1;

  // Access request from the dispatcher control to the server store.
  typedef struct packed {
    logic                rd_en;
    logic [SRV_ID_W-1:0] rd_addr;
    logic                wr_en;
    logic [SRV_ID_W-1:0] wr_addr;
    logic [END_W-1:0]    wr_busy;
    logic [CNT_W-1:0]    wr_count;
  } mem_req_t;

  // Registered read data of the server store.
  typedef struct packed {
    logic [END_W-1:0] busy;
    logic [CNT_W-1:0] count;
  } mem_rsp_t;

endpackage

### rtl/rsd_if.sv
// Valid/ready channel interfaces for requests and results.
interface rsd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [rsd_pkg::TIME_W-1:0] arrival_time;
  logic [rsd_pkg::TIME_W-1:0] load_time;

  modport source (output valid, output mode, output arrival_time, output load_time,
                  input ready);
  modport sink   (input valid, input mode, input arrival_time, input load_time,
                  output ready);
endinterface

interface rsd_out_if;
  logic                         valid;
  logic                         ready;
  logic [rsd_pkg::SRV_ID_W-1:0] server_id;
  logic                         accepted;
  logic [rsd_pkg::CNT_W-1:0]    handled_total;
  logic                         last;

  modport source (output valid, output server_id, output accepted, output handled_total,
                  output last, input ready);
  modport sink   (input valid, input server_id, input accepted, input handled_total,
                  input last, output ready);
endinterface

### rtl/rsd_store.sv
// Per-server store of end times and handled counts, with reset valid bits.
module rsd_store #(
  parameter int NUM_SERVERS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rsd_pkg::mem_req_t req,
  output rsd_pkg::mem_rsp_t rsp
);

  localparam int AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  logic [rsd_pkg::END_W-1:0] busy_mem [NUM_SERVERS];
  logic [rsd_pkg::CNT_W-1:0] cnt_mem  [NUM_SERVERS];
  logic [NUM_SERVERS-1:0]    valid_r;
  logic [rsd_pkg::END_W-1:0] rd_busy_r;
  logic [rsd_pkg::CNT_W-1:0] rd_cnt_r;
  logic                      rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      busy_mem[req.wr_addr[AW-1:0]] <= req.wr_busy;
      cnt_mem[req.wr_addr[AW-1:0]]  <= req.wr_count;
    end
    if (req.rd_en) begin
      rd_busy_r <= busy_mem[req.rd_addr[AW-1:0]];
      rd_cnt_r  <= cnt_mem[req.rd_addr[AW-1:0]];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr[AW-1:0]];
      end
    end
  end

  assign rsp.busy  = rd_valid_r ? rd_busy_r : '0;
  assign rsp.count = rd_valid_r ? rd_cnt_r : '0;

endmodule

### rtl/rotating_server_dispatcher_top.sv
// Top level of the rotating server dispatcher: control sequencer and result register.
//
// A dispatch beat (mode 0) examines the servers' end times one per cycle in rotation order,
// starting at the dispatch request number mod k, and takes the first server that is free
// at the arrival time; the server store has a single read port, which feeds one end time
// per cycle to the compare. A report beat (mode 1) first sweeps the k handled counts at one
// per cycle to find the maximum and the number of servers holding it, then revisits the
// servers in turn, reading and then checking each count, and emits one result beat per
// server that holds the maximum, the final one flagged last. A new beat is taken as soon as
// the previous item has handed its last result to the output register, so one result may
// still wait at the output while the next item runs. The store is empty after reset without
// any clearing pass: a valid bit per server makes an unwritten entry read as zero. The
// servers_in_use register is written through cfg_wr_en and cfg_wr_data; the user must write
// it only while the block is idle, and the block itself does not enforce this. A value of
// zero acts as one and a value above NUM_SERVERS acts as NUM_SERVERS.
module rotating_server_dispatcher_top #(
  parameter int NUM_SERVERS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rsd_in_if.sink                    in_ch,
  rsd_out_if.source                 out_ch,
  input  logic                      cfg_wr_en,
  input  logic [rsd_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int AW  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int CW  = $clog2(NUM_SERVERS + 1);
  localparam int IdW = rsd_pkg::SRV_ID_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DROP,
    ST_MAX,
    ST_LIST_RD,
    ST_LIST_CHK
  } state_t;

  state_t                      state_r;
  logic [rsd_pkg::CFG_W-1:0]   cfg_servers_r;
  logic [CW-1:0]               k_r;
  logic [CW-1:0]               start_r;
  logic [CW-1:0]               iss_r;
  logic [CW-1:0]               hits_r;
  logic [CW-1:0]               seen_r;
  logic [AW-1:0]               rot_r;
  logic [AW-1:0]               pidx_r;
  logic [AW-1:0]               pick_r;
  logic                        pend_r;
  logic [rsd_pkg::TIME_W-1:0]  arr_r;
  logic [rsd_pkg::TIME_W-1:0]  load_r;
  logic [rsd_pkg::CNT_W-1:0]   cnt_r;
  logic [rsd_pkg::CNT_W-1:0]   top_r;

  logic                        out_valid_r;
  logic [IdW-1:0]              out_id_r;
  logic                        out_acc_r;
  logic [rsd_pkg::CNT_W-1:0]   out_total_r;
  logic                        out_last_r;

  logic [CW-1:0]               k_act;
  logic [CW-1:0]               start_c;
  logic [CW:0]                 start_p1;
  logic [AW-1:0]               rot_nxt;
  logic [CW:0]                 scan_sum;
  logic [CW:0]                 scan_wrap;
  logic [AW-1:0]               issue_addr;
  logic                        issue;
  logic                        more;
  logic                        hit;
  logic                        in_fire;
  logic                        out_free;
  logic                        list_last;
  logic [rsd_pkg::CNT_W-1:0]   cnt_inc;

  rsd_pkg::mem_req_t           mem_req;
  rsd_pkg::mem_rsp_t           mem_rsp;

  rsd_store #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rsp   (mem_rsp)
  );

  // Effective number of servers, clamped into the supported range.
  always_comb begin
    priority if (cfg_servers_r == '0) begin
      k_act = CW'(1);
    end else if (cfg_servers_r > rsd_pkg::CFG_W'(NUM_SERVERS)) begin
      k_act = CW'(NUM_SERVERS);
    end else begin
      k_act = cfg_servers_r[CW-1:0];
    end
  end

  // The rotation restarts at server zero when k was lowered below it.
  assign start_c  = (CW'(rot_r) < k_act) ? CW'(rot_r) : '0;
  assign start_p1 = {1'b0, start_c} + (CW+1)'(1);
  assign rot_nxt  = (start_p1 >= {1'b0, k_act}) ? '0 : AW'(start_p1);

  // Scan address: start plus offset, wrapped once at k.
  assign scan_sum  = {1'b0, start_r} + {1'b0, iss_r};
  assign scan_wrap = (scan_sum >= {1'b0, k_r}) ? (scan_sum - {1'b0, k_r}) : scan_sum;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign more      = iss_r < k_r;
  assign hit       = pend_r && (mem_rsp.busy <= {1'b0, arr_r});
  assign list_last = (seen_r + CW'(1)) == hits_r;
  assign cnt_inc   = (mem_rsp.count == '1) ? mem_rsp.count
                                           : mem_rsp.count + rsd_pkg::CNT_W'(1);

  always_comb begin
    unique case (state_r)
      ST_SCAN:    issue = more && !hit;
      ST_MAX:     issue = more;
      ST_LIST_RD: issue = 1'b1;
      default:    issue = 1'b0;
    endcase
    issue_addr = (state_r == ST_SCAN) ? AW'(scan_wrap) : AW'(iss_r);
  end

  // The write-back happens only after the scan has stopped issuing reads, so a read and a
  // write never meet at the same entry.
  always_comb begin
    mem_req.rd_en    = issue;
    mem_req.rd_addr  = IdW'(issue_addr);
    mem_req.wr_en    = (state_r == ST_WRITE);
    mem_req.wr_addr  = IdW'(pick_r);
    mem_req.wr_busy  = {1'b0, arr_r} + {1'b0, load_r};
    mem_req.wr_count = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cfg_servers_r <= rsd_pkg::CFG_RESET;
      rot_r         <= '0;
      pend_r        <= 1'b0;
      iss_r         <= '0;
      hits_r        <= '0;
      seen_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_servers_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      pend_r <= issue;
      if (issue) begin
        pidx_r <= issue_addr;
        iss_r  <= iss_r + CW'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            k_r    <= k_act;
            iss_r  <= '0;
            arr_r  <= in_ch.arrival_time;
            load_r <= in_ch.load_time;
            if (in_ch.mode == rsd_pkg::MODE_REPORT) begin
              top_r   <= '0;
              hits_r  <= '0;
              state_r <= ST_MAX;
            end else begin
              start_r <= start_c;
              rot_r   <= rot_nxt;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            pick_r  <= pidx_r;
            cnt_r   <= cnt_inc;
            state_r <= ST_WRITE;
          end else if (pend_r && !more) begin
            state_r <= ST_DROP;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_id_r    <= IdW'(pick_r);
            out_acc_r   <= 1'b1;
            out_total_r <= cnt_r;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_DROP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_id_r    <= '0;
            out_acc_r   <= 1'b0;
            out_total_r <= '0;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_MAX: begin
          if (pend_r) begin
            if (mem_rsp.count > top_r) begin
              top_r  <= mem_rsp.count;
              hits_r <= CW'(1);
            end else if (mem_rsp.count == top_r) begin
              hits_r <= hits_r + CW'(1);
            end
            if (!more) begin
              iss_r   <= '0;
              seen_r  <= '0;
              state_r <= ST_LIST_RD;
            end
          end
        end
        ST_LIST_RD: begin
          state_r <= ST_LIST_CHK;
        end
        ST_LIST_CHK: begin
          if (mem_rsp.count == top_r) begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_id_r    <= IdW'(pidx_r);
              out_acc_r   <= 1'b1;
              out_total_r <= mem_rsp.count;
              out_last_r  <= list_last;
              seen_r      <= seen_r + CW'(1);
              state_r     <= list_last ? ST_IDLE : ST_LIST_RD;
            end
          end else begin
            state_r <= ST_LIST_RD;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.server_id     = out_id_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.handled_total = out_total_r;
  assign out_ch.last          = out_last_r;

endmodule

### rtl/rsd_checker.sv
// Port-level assertions for the rotating server dispatcher, bound to the top level.
module rsd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rsd_pkg::SRV_ID_W-1:0] out_server_id,
  input logic                         out_accepted,
  input logic [rsd_pkg::CNT_W-1:0]    out_handled_total,
  input logic                         out_last
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_server_id, out_accepted, out_handled_total, out_last}))
    else $error("result beat changed while stalled");

  // Items are worked one at a time: a taken beat closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is still in work");

  // A dropped request is a single, fully zeroed result beat.
  a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |->
      out_last && out_server_id == '0 && out_handled_total == '0)
    else $error("dropped request with wrong result fields");

  // Reset empties the result register.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

endmodule

bind rotating_server_dispatcher_top rsd_checker u_rsd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_server_id     (out_ch.server_id),
  .out_accepted      (out_ch.accepted),
  .out_handled_total (out_ch.handled_total),
  .out_last          (out_ch.last)
);
